/* hdl/tvm_pkg.sv */
package tvm_pkg;

    localparam int VOICES_DEF    = 16;
    localparam int SINE_BITS_DEF = 10;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] ROUTE_LEFT  = 2'd1;
    localparam logic [1:0] ROUTE_RIGHT = 2'd2;

    localparam int ATK_LEN = 96;
    localparam int REL_LEN = 192;

    localparam logic [14:0] VOL_MAX  = 15'd16384;
    localparam logic [16:0] GAIN_MAX = 17'd65536;

    // step = floor((freq * 2^21 + 187) / 375), always below 2^32
    // split as freq = hi * 375 + lo, step = {hi, floor((lo * 2^21 + 187) / 375)}
    localparam logic [8:0]  STEP_DIVISOR  = 9'd375;
    localparam logic [29:0] STEP_ROUND    = 30'd187;
    // ceil(2^28 / 375), exact for numerators below 2^19
    localparam logic [19:0] STEP_RECIP_HI = 20'd715828;
    // ceil(2^39 / 375), exact for numerators below 2^30
    localparam logic [30:0] STEP_RECIP_LO = 31'd1466015504;

    // width of one weighted voice term and of the frame shift
    localparam int W_BITS    = 49;
    localparam int MIX_SHIFT = 30;

    localparam int RECIP_DEPTH = 256;

    typedef struct packed {
        logic        active;
        logic [31:0] phase;
        logic [31:0] step;
        logic [21:0] pos;
        logic [21:0] len;
        logic [16:0] gain;
        logic [1:0]  chan;
    } t_voice;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic issue;
        logic clr;
    } t_unit_ctl;

    typedef logic [32:0] t_recip_tbl [RECIP_DEPTH];

    // ceil(2^32 / d), exact floor divide for numerators below 2^23
    function automatic logic [32:0] f_recip(input logic [7:0] d);
        logic [33:0] num;
        logic [33:0] rem;
        logic [33:0] quo;
        num = 34'h1_0000_0000 + 34'(d) - 34'd1;
        rem = '0;
        quo = '0;
        if (d == 8'd0) begin
            return '0;
        end
        for (int b = 33; b >= 0; b--) begin
            rem = {rem[32:0], num[b]};
            if (rem >= 34'(d)) begin
                rem    = rem - 34'(d);
                quo[b] = 1'b1;
            end
        end
        return quo[32:0];
    endfunction

    function automatic t_recip_tbl f_recip_tbl();
        t_recip_tbl t;
        for (int d = 0; d < RECIP_DEPTH; d++) begin
            t[d] = f_recip(8'(d));
        end
        return t;
    endfunction

    localparam t_recip_tbl RECIP_TBL = f_recip_tbl();

    function automatic logic [63:0] f_quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] y;
        x2 = (x * x) >> 16;
        t  = (64'd4640 * x2) >> 16;
        t  = 64'd42047 - t;
        t  = (x2 * t) >> 16;
        t  = 64'd102944 - t;
        y  = (x * t) >> 16;
        y  = (y + 64'd1) >> 1;
        if (y > 64'd32767) begin
            y = 64'd32767;
        end
        return y;
    endfunction

    function automatic logic signed [15:0] f_sine(input int bits, input int k);
        int          quarter;
        int          q;
        int          r;
        int          u;
        logic [63:0] v;
        quarter = 1 << (bits - 2);
        q = k >> (bits - 2);
        r = k & (quarter - 1);
        u = ((q & 1) != 0) ? (quarter - r) : r;
        v = f_quarter_sine(64'(u) << (18 - bits));
        if ((q & 2) != 0) begin
            v = -v;
        end
        return v[15:0];
    endfunction

endpackage

/* hdl/tone_voice_mixer_core.sv */
// channel   direction  handshake                 payload
// in        to core    i_valid / o_ready         i_kind i_tone_freq i_tone_ms i_tone_gain
//                                                i_tone_route
// out       from core  o_valid / i_ready         o_left_sample o_right_sample o_accepted
//                                                o_dropped_count
// cfg       to core    i_cfg_valid / o_cfg_ready i_cfg_master_volume
//
// clear, tick-less kinds and rejected adds: result appears in the cycle after the item is taken
// add: the pipelined step divide runs first, then the voice ring
// rotates once past the insert point
// tick: one rotation of the voice ring through the mix pipeline, then the pipeline drains
// reset (synchronous, active low) empties the voice ring and the drop counter at once
// a result waiting on i_ready holds off the next item until it is taken
module tone_voice_mixer_core
    import tvm_pkg::*;
#(
    parameter int VOICES          = VOICES_DEF,
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [18:0]        i_tone_freq,
    input  logic [15:0]        i_tone_ms,
    input  logic [16:0]        i_tone_gain,
    input  logic [1:0]         i_tone_route,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    output logic               o_accepted,
    output logic [15:0]        o_dropped_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [14:0]        i_cfg_master_volume
);

    localparam int CW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = W_BITS + $clog2(VOICES);
    localparam int SW = AW - MIX_SHIFT;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_TICK  = 5'b01000,
        S_DRAIN = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_placed, n_placed;
    t_voice             r_new, n_new;
    logic [14:0]        r_vol;
    logic [15:0]        r_drop, n_drop;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_left, n_left;
    logic signed [15:0] r_right, n_right;
    logic               r_acc, n_acc;

    t_cell_ctl cell_ctl;
    t_unit_ctl unit_ctl;
    t_voice    ring [VOICES];
    t_voice    head;
    t_voice    tail;
    t_voice    unit_next;
    t_voice    new_voice;
    logic      unit_busy;
    logic      div_start;
    logic      div_done;
    logic [31:0] div_quot;
    logic      take_in;
    logic      take_slot;
    logic [17:0] vol5;
    logic [14:0] vol;

    logic signed [AW-1:0] acc_l;
    logic signed [AW-1:0] acc_r;
    logic signed [SW-1:0] sh_l;
    logic signed [SW-1:0] sh_r;
    logic signed [15:0]   sat_l;
    logic signed [15:0]   sat_r;

    assign vol  = (r_vol > VOL_MAX) ? VOL_MAX : r_vol;
    assign vol5 = {3'b0, vol} + {1'b0, vol, 2'b0};

    assign o_ready     = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign take_in     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign head = ring[VOICES-1];

    genvar g;
    generate
        for (g = 0; g < VOICES; g++) begin : g_cell
            if (g == 0) begin : g_first
                tvm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (cell_ctl),
                    .i_voice (tail),
                    .o_voice (ring[g])
                );
            end else begin : g_rest
                tvm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (cell_ctl),
                    .i_voice (ring[g-1]),
                    .o_voice (ring[g])
                );
            end
        end
    endgenerate

    tvm_step_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_freq  (i_tone_freq),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tvm_voice_unit #(
        .VOICES          (VOICES),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (unit_ctl),
        .i_head  (head),
        .i_vol5  (vol5),
        .o_next  (unit_next),
        .o_busy  (unit_busy),
        .o_acc_l (acc_l),
        .o_acc_r (acc_r)
    );

    // floor to q0.15 and saturate
    always_comb begin
        sh_l = acc_l[AW-1:MIX_SHIFT];
        sh_r = acc_r[AW-1:MIX_SHIFT];
        if (sh_l > SW'(32767)) begin
            sat_l = 16'sd32767;
        end else if (sh_l < -SW'(32768)) begin
            sat_l = -16'sd32768;
        end else begin
            sat_l = sh_l[15:0];
        end
        if (sh_r > SW'(32767)) begin
            sat_r = 16'sd32767;
        end else if (sh_r < -SW'(32768)) begin
            sat_r = -16'sd32768;
        end else begin
            sat_r = sh_r[15:0];
        end
    end

    always_comb begin
        new_voice      = r_new;
        new_voice.step = div_quot;
        take_slot      = !r_placed && !head.active;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_placed    = r_placed;
        n_new       = r_new;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !i_ready;
        n_left      = r_left;
        n_right     = r_right;
        n_acc       = r_acc;
        cell_ctl    = '0;
        unit_ctl    = '0;
        tail        = head;
        div_start   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    n_left  = '0;
                    n_right = '0;
                    n_acc   = 1'b0;
                    case (i_kind)
                        KIND_ADD: begin
                            if (i_tone_freq != '0 && i_tone_ms != '0) begin
                                n_new.active = 1'b1;
                                n_new.phase  = '0;
                                n_new.step   = '0;
                                n_new.pos    = '0;
                                n_new.len    = {1'b0, i_tone_ms, 5'b0}
                                             + {2'b0, i_tone_ms, 4'b0};
                                n_new.gain   = (i_tone_gain > GAIN_MAX) ? GAIN_MAX
                                                                        : i_tone_gain;
                                n_new.chan   = (i_tone_route == ROUTE_LEFT)  ? 2'b01 :
                                               (i_tone_route == ROUTE_RIGHT) ? 2'b10 : 2'b11;
                                div_start    = 1'b1;
                                n_state      = S_DIV;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        KIND_TICK: begin
                            unit_ctl.clr = 1'b1;
                            n_cnt        = '0;
                            n_state      = S_TICK;
                        end
                        KIND_CLEAR: begin
                            cell_ctl.clear = 1'b1;
                            n_out_valid    = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_cnt    = '0;
                    n_placed = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // new voice goes into the first free slot that rotates past
                cell_ctl.shift = 1'b1;
                tail           = take_slot ? new_voice : head;
                n_placed       = r_placed || take_slot;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(VOICES - 1)) begin
                    n_acc       = n_placed;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (!n_placed && r_drop != 16'hFFFF) begin
                        n_drop = r_drop + 16'd1;
                    end
                end
            end
            S_TICK: begin
                cell_ctl.shift = 1'b1;
                unit_ctl.issue = 1'b1;
                tail           = unit_next;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(VOICES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!unit_busy) begin
                    n_left      = sat_l;
                    n_right     = sat_r;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_placed    <= 1'b0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
            r_vol       <= VOL_MAX;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_placed    <= n_placed;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_vol <= i_cfg_master_volume;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new   <= n_new;
        r_left  <= n_left;
        r_right <= n_right;
        r_acc   <= n_acc;
    end

    assign o_valid         = r_out_valid;
    assign o_left_sample   = r_left;
    assign o_right_sample  = r_right;
    assign o_accepted      = r_acc;
    assign o_dropped_count = r_drop;

endmodule

/* hdl/tvm_cell.sv */
module tvm_cell
    import tvm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_voice    i_voice,
    output t_voice    o_voice
);

    logic   r_active;
    t_voice r_voice;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_ctl.clear) begin
            r_active <= 1'b0;
        end else if (i_ctl.shift) begin
            r_active <= i_voice.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_voice <= i_voice;
        end
    end

    always_comb begin
        o_voice        = r_voice;
        o_voice.active = r_active;
    end

endmodule

/* hdl/tvm_step_div.sv */
module tvm_step_div
    import tvm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [18:0] i_freq,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic [2:0]  r_v;
    logic        r_done;
    logic [18:0] r_freq;
    logic [10:0] r_hi;
    logic [29:0] r_lo_num;
    logic [31:0] r_quot;

    logic [38:0] prod_hi;
    logic [19:0] prod_back;
    logic [18:0] lo;
    logic [60:0] prod_lo;

    // reciprocal multiplies, one step a cycle
    assign prod_hi   = r_freq * STEP_RECIP_HI;
    assign prod_back = r_hi * STEP_DIVISOR;
    assign lo        = r_freq - prod_back[18:0];
    assign prod_lo   = r_lo_num * STEP_RECIP_LO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[1:0], i_start};
            r_done <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_freq <= i_freq;
        end
        if (r_v[0]) begin
            r_hi <= prod_hi[38:28];
        end
        if (r_v[1]) begin
            r_lo_num <= {lo[8:0], 21'b0} + STEP_ROUND;
        end
        if (r_v[2]) begin
            r_quot <= {r_hi, prod_lo[59:39]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hdl/tvm_voice_unit.sv */
module tvm_voice_unit
    import tvm_pkg::*;
#(
    parameter int VOICES          = VOICES_DEF,
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_unit_ctl                              i_ctl,
    input  t_voice                                 i_head,
    input  logic [17:0]                            i_vol5,
    output t_voice                                 o_next,
    output logic                                   o_busy,
    output logic signed [W_BITS+$clog2(VOICES)-1:0] o_acc_l,
    output logic signed [W_BITS+$clog2(VOICES)-1:0] o_acc_r
);

    localparam int TBL = 1 << SINE_TABLE_BITS;
    localparam int AW  = W_BITS + $clog2(VOICES);

    typedef logic signed [15:0] t_rom [TBL];

    function automatic t_rom f_rom();
        t_rom t;
        for (int k = 0; k < TBL; k++) begin
            t[k] = f_sine(SINE_TABLE_BITS, k);
        end
        return t;
    endfunction

    localparam t_rom SINE_ROM = f_rom();

    // advance the head voice as it goes back into the ring
    logic [22:0] pos1;

    always_comb begin
        pos1          = {1'b0, i_head.pos} + 23'd1;
        o_next        = i_head;
        o_next.phase  = i_head.phase + i_head.step;
        o_next.pos    = pos1[21:0];
        o_next.active = i_head.active && (pos1 < {1'b0, i_head.len});
    end

    // stage 0: envelope operands and table reads
    logic [6:0]  atk;
    logic [7:0]  rel;
    logic [21:0] rem;
    logic        use_a;
    logic        use_r;

    always_comb begin
        atk   = (i_head.len < 22'(ATK_LEN)) ? i_head.len[6:0] : 7'(ATK_LEN);
        rel   = (i_head.len < 22'(REL_LEN)) ? i_head.len[7:0] : 8'(REL_LEN);
        rem   = (i_head.len > i_head.pos) ? (i_head.len - i_head.pos - 22'd1) : '0;
        use_a = (atk > 7'd1) && (i_head.pos < 22'(atk));
        use_r = (rel > 8'd1) && (rem < 22'(rel));
    end

    logic [6:1] r_v;

    logic signed [15:0] r1_sine;
    logic [21:0]        r1_na;
    logic [22:0]        r1_nr;
    logic [32:0]        r1_ma;
    logic [32:0]        r1_mr;
    logic               r1_ua;
    logic               r1_ur;
    logic [16:0]        r1_gain;
    logic [1:0]         r1_chan;

    logic signed [15:0] r2_sine;
    logic [15:0]        r2_ea;
    logic [15:0]        r2_er;
    logic [16:0]        r2_gain;
    logic [1:0]         r2_chan;

    logic signed [15:0] r3_sine;
    logic [15:0]        r3_env;
    logic [16:0]        r3_gain;
    logic [1:0]         r3_chan;

    logic signed [16:0] r4_smp;
    logic [16:0]        r4_gain;
    logic [1:0]         r4_chan;

    logic signed [34:0] r5_p;
    logic [1:0]         r5_chan;

    logic signed [W_BITS-1:0] r6_w;
    logic [1:0]               r6_chan;

    logic signed [AW-1:0] r_acc_l;
    logic signed [AW-1:0] r_acc_r;

    logic [54:0]        prod_a;
    logic [55:0]        prod_r;
    logic [31:0]        prod_env;
    logic signed [32:0] prod_s;
    logic signed [53:0] prod_w;

    assign prod_a   = r1_na * r1_ma;
    assign prod_r   = r1_nr * r1_mr;
    assign prod_env = r2_ea * r2_er;
    assign prod_s   = r3_sine * $signed({1'b0, r3_env});
    assign prod_w   = r5_p * $signed({1'b0, i_vol5});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:1], i_ctl.issue && i_head.active};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sine <= SINE_ROM[i_head.phase[31 -: SINE_TABLE_BITS]];
        r1_na   <= {i_head.pos[6:0], 15'b0};
        r1_nr   <= {rem[7:0], 15'b0};
        r1_ma   <= RECIP_TBL[8'(atk) - 8'd1];
        r1_mr   <= RECIP_TBL[rel - 8'd1];
        r1_ua   <= use_a;
        r1_ur   <= use_r;
        r1_gain <= i_head.gain;
        r1_chan <= i_head.chan;

        r2_sine <= r1_sine;
        r2_ea   <= r1_ua ? prod_a[47:32] : 16'd32768;
        r2_er   <= r1_ur ? prod_r[47:32] : 16'd32768;
        r2_gain <= r1_gain;
        r2_chan <= r1_chan;

        r3_sine <= r2_sine;
        r3_env  <= prod_env[30:15];
        r3_gain <= r2_gain;
        r3_chan <= r2_chan;

        // arithmetic shift floors toward minus infinity
        r4_smp  <= prod_s[31:15];
        r4_gain <= r3_gain;
        r4_chan <= r3_chan;

        r5_p    <= r4_smp * $signed({1'b0, r4_gain});
        r5_chan <= r4_chan;

        r6_w    <= prod_w[W_BITS-1:0];
        r6_chan <= r5_chan;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_v[6]) begin
            if (r6_chan[0]) begin
                r_acc_l <= r_acc_l + AW'(r6_w);
            end
            if (r6_chan[1]) begin
                r_acc_r <= r_acc_r + AW'(r6_w);
            end
        end
    end

    assign o_busy  = |r_v;
    assign o_acc_l = r_acc_l;
    assign o_acc_r = r_acc_r;

endmodule

/* verif/tvm_checker.sv */
module tvm_checker
    import tvm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [18:0]        i_tone_freq,
    input  logic [15:0]        i_tone_ms,
    input  logic [16:0]        i_tone_gain,
    input  logic [1:0]         i_tone_route,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [15:0] o_left_sample,
    input  logic signed [15:0] o_right_sample,
    input  logic               o_accepted,
    input  logic [15:0]        o_dropped_count,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [14:0]        i_cfg_master_volume,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int NVOICE   = 16;
    localparam int LUT_BITS = 10;
    localparam int LUT_SIZE = 1 << LUT_BITS;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               accepted;
        logic [15:0]        drops;
    } t_frame;

    longint sine_lut [LUT_SIZE];

    logic        act   [NVOICE];
    logic [31:0] phase [NVOICE];
    logic [31:0] step  [NVOICE];
    logic [21:0] pos   [NVOICE];
    logic [21:0] len   [NVOICE];
    logic [16:0] gain  [NVOICE];
    logic [1:0]  chan  [NVOICE];
    logic [15:0] drop_total;
    logic [14:0] volume;

    t_frame expected_frames [$];
    int     fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_frames.size();

    // polynomial quarter wave, x in Q16
    function automatic longint quarter_wave(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] y;
        x2 = (x * x) >> 16;
        t  = (64'd4640 * x2) >> 16;
        t  = 64'd42047 - t;
        t  = (x2 * t) >> 16;
        t  = 64'd102944 - t;
        y  = (x * t) >> 16;
        y  = (y + 64'd1) >> 1;
        if (y > 64'd32767) begin
            y = 64'd32767;
        end
        return longint'(y);
    endfunction

    initial begin
        int quarter;
        int q;
        int r;
        int u;
        longint v;
        quarter = LUT_SIZE / 4;
        for (int k = 0; k < LUT_SIZE; k++) begin
            q = k / quarter;
            r = k % quarter;
            u = (q & 1) ? (quarter - r) : r;
            v = quarter_wave(64'(u) << (18 - LUT_BITS));
            sine_lut[k] = (q & 2) ? -v : v;
        end
        fail_count = 0;
    end

    function automatic t_frame mix_predict(input logic [1:0] kind, input logic [18:0] freq,
                                           input logic [15:0] ms, input logic [16:0] g,
                                           input logic [1:0] route);
        t_frame f;
        int     slot;
        longint acc_l;
        longint acc_r;
        longint vol5;
        longint l;
        longint i;
        longint atk;
        longint rel;
        longint rem;
        longint ea;
        longint er;
        longint env;
        longint smp;
        longint w;
        f.left     = '0;
        f.right    = '0;
        f.accepted = 1'b0;
        if (kind == KIND_ADD) begin
            if (freq != 0 && ms != 0) begin
                slot = -1;
                for (int v = 0; v < NVOICE; v++) begin
                    if (slot < 0 && !act[v]) slot = v;
                end
                if (slot < 0) begin
                    if (drop_total != 16'hFFFF) drop_total++;
                end else begin
                    act[slot]   = 1'b1;
                    phase[slot] = '0;
                    step[slot]  = 32'(((64'(freq) << 28) + 64'd24000) / 64'd48000);
                    pos[slot]   = '0;
                    len[slot]   = 22'(ms * 48);
                    gain[slot]  = (g > GAIN_MAX) ? GAIN_MAX : g;
                    chan[slot]  = (route == ROUTE_LEFT) ? 2'd1 :
                                  (route == ROUTE_RIGHT) ? 2'd2 : 2'd3;
                    f.accepted  = 1'b1;
                end
            end
        end else if (kind == KIND_TICK) begin
            vol5  = longint'((volume > VOL_MAX) ? VOL_MAX : volume) * 5;
            acc_l = 0;
            acc_r = 0;
            for (int v = 0; v < NVOICE; v++) begin
                if (act[v]) begin
                    l   = len[v];
                    i   = pos[v];
                    atk = (l < ATK_LEN) ? l : ATK_LEN;
                    rel = (l < REL_LEN) ? l : REL_LEN;
                    rem = (l > i) ? (l - 1 - i) : 0;
                    ea  = 32768;
                    er  = 32768;
                    if (atk > 1 && i < atk) ea = (i * 32768) / (atk - 1);
                    if (rel > 1 && rem < rel) er = (rem * 32768) / (rel - 1);
                    env = (ea * er) >> 15;
                    smp = (sine_lut[phase[v][31 -: LUT_BITS]] * env) >>> 15;
                    w   = smp * longint'(gain[v]) * vol5;
                    if (chan[v][0]) acc_l += w;
                    if (chan[v][1]) acc_r += w;
                    phase[v] = phase[v] + step[v];
                    pos[v]   = 22'(i + 1);
                    if (pos[v] >= l || i + 1 >= l) act[v] = 1'b0;
                end
            end
            acc_l = acc_l >>> 30;
            acc_r = acc_r >>> 30;
            f.left  = (acc_l > 32767) ? 16'sd32767 : (acc_l < -32768) ? -16'sd32768 : 16'(acc_l);
            f.right = (acc_r > 32767) ? 16'sd32767 : (acc_r < -32768) ? -16'sd32768 : 16'(acc_r);
        end else if (kind == KIND_CLEAR) begin
            for (int v = 0; v < NVOICE; v++) act[v] = 1'b0;
        end
        f.drops = drop_total;
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_frame want;
        t_frame pred;
        if (!i_rst_n) begin
            for (int v = 0; v < NVOICE; v++) act[v] = 1'b0;
            drop_total = '0;
            volume     = VOL_MAX;
            expected_frames.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result with nothing expected: %0d %0d %0d %0d", $time,
                             o_left_sample, o_right_sample, o_accepted, o_dropped_count);
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (want.left !== o_left_sample) begin
                        $display("%0t: left expected %0d actual %0d", $time,
                                 want.left, o_left_sample);
                        fail_count++;
                    end
                    if (want.right !== o_right_sample) begin
                        $display("%0t: right expected %0d actual %0d", $time,
                                 want.right, o_right_sample);
                        fail_count++;
                    end
                    if (want.accepted !== o_accepted) begin
                        $display("%0t: accepted expected %0d actual %0d", $time,
                                 want.accepted, o_accepted);
                        fail_count++;
                    end
                    if (want.drops !== o_dropped_count) begin
                        $display("%0t: dropped expected %0d actual %0d", $time,
                                 want.drops, o_dropped_count);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                pred = mix_predict(i_kind, i_tone_freq, i_tone_ms, i_tone_gain, i_tone_route);
                expected_frames.insert(expected_frames.size(), pred);
            end
            if (i_cfg_valid && o_cfg_ready) volume = i_cfg_master_volume;
        end
    end

endmodule

/* verif/tb_top.sv */
module tb_top;
    import tvm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] KIND_NONE = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_kind = KIND_TICK;
    logic [18:0]        i_tone_freq = '0;
    logic [15:0]        i_tone_ms = '0;
    logic [16:0]        i_tone_gain = '0;
    logic [1:0]         i_tone_route = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_left_sample;
    logic signed [15:0] o_right_sample;
    logic               o_accepted;
    logic [15:0]        o_dropped_count;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [14:0]        i_cfg_master_volume = '0;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    bit  no_gaps = 1'b0;
    bit  hold_sink = 1'b0;

    tone_voice_mixer_core u_dut (.*);

    tvm_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_tone_freq, .i_tone_ms,
        .i_tone_gain, .i_tone_route, .o_valid, .i_ready, .o_left_sample,
        .o_right_sample, .o_accepted, .o_dropped_count, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_master_volume, .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sink side: random stalls, plus one long hold-off on request
    initial begin
        int  n;
        bit  took;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = o_valid;
                @(posedge i_clk);
            end while (!took);
        end
    end

    // valid stays high between back-to-back items, lowered only before a gap
    task automatic send_item(input logic [1:0] kind, input logic [18:0] freq,
                             input logic [15:0] ms, input logic [16:0] g,
                             input logic [1:0] route);
        int n;
        bit took;
        n = no_gaps ? 0 : $urandom_range(0, 6);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_tone_freq  <= freq;
        i_tone_ms    <= ms;
        i_tone_gain  <= g;
        i_tone_route <= route;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_volume(input logic [14:0] vol);
        bit took;
        drain_results();
        repeat (80) @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_master_volume <= vol;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int          r;
        logic [1:0]  kind;
        logic [15:0] ms;
        r = $urandom_range(0, 99);
        kind = (r < 30) ? KIND_ADD : (r < 88) ? KIND_TICK : (r < 94) ? KIND_CLEAR : KIND_NONE;
        r = $urandom_range(0, 99);
        ms = (r < 85) ? 16'($urandom_range(1, 4)) :
             (r < 92) ? 16'($urandom_range(0, 65535)) : 16'd0;
        send_item(kind,
                  ($urandom_range(0, 19) == 0) ? 19'($urandom_range(0, 524287)) :
                      19'($urandom_range(1, 393216)),
                  ms, 17'($urandom_range(0, 131071)), 2'($urandom_range(0, 3)));
    endtask

    initial begin
        logic [14:0] vols [5];
        vols[0] = VOL_MAX;
        vols[1] = 15'h7FFF;
        vols[2] = '0;
        vols[3] = 15'($urandom_range(0, 32767));
        vols[4] = 15'd8192;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every route, rejects, kind three, full table
        send_item(KIND_ADD, 19'd393216, 16'd1, GAIN_MAX, 2'd0);
        send_item(KIND_ADD, 19'd16000, 16'd2, 17'h1FFFF, ROUTE_LEFT);
        send_item(KIND_ADD, 19'd7040, 16'd3, 17'd16384, ROUTE_RIGHT);
        send_item(KIND_ADD, 19'h7FFFF, 16'd1, 17'd40000, 2'd3);
        send_item(KIND_ADD, 19'd0, 16'd5, 17'd16384, 2'd0);
        send_item(KIND_ADD, 19'd1000, 16'd0, 17'd16384, 2'd0);
        send_item(KIND_NONE, 19'h7FFFF, 16'hFFFF, 17'h1FFFF, 2'd3);
        for (int k = 0; k < 6; k++) send_item(KIND_TICK, '0, '0, '0, '0);
        send_item(KIND_CLEAR, '0, '0, '0, '0);
        for (int k = 0; k < 17; k++)
            send_item(KIND_ADD, 19'(1 + k * 20000), 16'hFFFF, 17'd65536, 2'(k));
        send_item(KIND_TICK, '0, '0, '0, '0);
        send_item(KIND_CLEAR, '0, '0, '0, '0);

        for (int ph = 0; ph < 5; ph++) begin
            write_volume(vols[ph]);
            no_gaps = (ph == 3);
            for (int k = 0; k < 100; k++) begin
                if (ph == 1 && k == 10) hold_sink = 1'b1;
                if (ph == 2 && k == 50) begin
                    drain_results();
                    repeat (30) @(posedge i_clk);
                end
                random_item();
            end
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/tvm_pkg.sv
hdl/tvm_cell.sv
hdl/tvm_step_div.sv
hdl/tvm_voice_unit.sv
hdl/tone_voice_mixer_core.sv
verif/tvm_checker.sv
verif/tb_top.sv
